FILE: hw/rtl/biphase_ir_frame_decoder_assert.svh
// Assertion macros for the bi-phase IR frame decoder.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef BIPHASE_IR_FRAME_DECODER_ASSERT_SVH
`define BIPHASE_IR_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BIPIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define BIPIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BIPIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BIPIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/bipir_pkg.sv
package bipir_pkg;

    localparam int WIDTH_W   = 16;
    localparam int SHIFT_W   = 16;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Frame length in bits, leading 1 bit included
    localparam int FRAME_BITS = 14;
    localparam logic [COUNT_W-1:0] FRAME_COUNT = COUNT_W'(FRAME_BITS);

    localparam logic [WIDTH_W-1:0] SHORT_MIN_RST = 16'd640;
    localparam logic [WIDTH_W-1:0] SHORT_MAX_RST = 16'd1140;
    localparam logic [WIDTH_W-1:0] LONG_MIN_RST  = 16'd1340;
    localparam logic [WIDTH_W-1:0] LONG_MAX_RST  = 16'd2220;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX  = 2'd3;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_MID1   = 3'd1,
        PH_START1 = 3'd2,
        PH_MID0   = 3'd3,
        PH_START0 = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_LONG  = 2'd2
    } t_pulse_cls;

    typedef struct packed {
        logic [WIDTH_W-1:0] short_min;
        logic [WIDTH_W-1:0] short_max;
        logic [WIDTH_W-1:0] long_min;
        logic [WIDTH_W-1:0] long_max;
    } t_cfg;

    typedef struct packed {
        logic [SHIFT_W-1:0] command;
        logic               frame_error;
        logic [COUNT_W-1:0] bits_received;
    } t_result;

endpackage

FILE: hw/rtl/biphase_ir_frame_decoder.sv
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_stall    i_pulse_width[15:0]
// out      out  o_out_valid / i_out_stall  o_command[15:0], o_frame_error, o_bits_received[4:0]
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index[1:0], i_cfg_wdata[15:0]
//
// One pulse width per cycle sustained while the skid entry is free: input register,
// combinational classify and phase update, then a result register with a skid entry.
// A result enters the result register or skid entry when the frame's last pulse is decoded.
// Synchronous active-low reset; windows return to their defaults, decoder to start phase.
// Input stalls only while the pulse register is full and the skid entry is occupied.
`include "biphase_ir_frame_decoder_assert.svh"

module biphase_ir_frame_decoder
    import bipir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WIDTH_W-1:0]   i_pulse_width,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SHIFT_W-1:0]   o_command,
    output logic                 o_frame_error,
    output logic [COUNT_W-1:0]   o_bits_received,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH_W-1:0]   i_cfg_wdata
);

    t_cfg               cfg;
    logic               r_pw_valid;
    logic [WIDTH_W-1:0] r_pw;
    logic               in_xfer;
    logic               dec_fire;
    logic               res_valid;
    t_result            res;
    logic               buf_full;
    t_result            out_data;

    bipir_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign dec_fire   = r_pw_valid && !buf_full;
    assign o_in_stall = r_pw_valid && buf_full;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_valid <= 1'b0;
        end else begin
            r_pw_valid <= in_xfer || (r_pw_valid && !dec_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pw <= i_pulse_width;
        end
    end

    bipir_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (dec_fire),
        .i_width     (r_pw),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bipir_out_buf u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (res_valid),
        .i_load       (res),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_data       (out_data),
        .o_full       (buf_full)
    );

    assign o_command       = out_data.command;
    assign o_frame_error   = out_data.frame_error;
    assign o_bits_received = out_data.bits_received;

    `BIPIR_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, res_valid, !buf_full)
    `BIPIR_ASSERT_IMPLY(a_skid_behind_head, i_clk, i_rst_n, buf_full, o_out_valid)
    `BIPIR_ASSERT_IMPLY(a_full_frame_len, i_clk, i_rst_n, o_out_valid && !o_frame_error,
        o_bits_received == FRAME_COUNT)
    `BIPIR_ASSERT_NEXT(a_pulse_held, i_clk, i_rst_n, r_pw_valid && !dec_fire,
        r_pw_valid && $stable(r_pw))

endmodule

FILE: hw/rtl/bipir_cfg_regs.sv
module bipir_cfg_regs
    import bipir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH_W-1:0]   i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHORT_MIN: n_cfg.short_min = i_cfg_wdata;
                REG_SHORT_MAX: n_cfg.short_max = i_cfg_wdata;
                REG_LONG_MIN:  n_cfg.long_min  = i_cfg_wdata;
                REG_LONG_MAX:  n_cfg.long_max  = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_min <= SHORT_MIN_RST;
            r_cfg.short_max <= SHORT_MAX_RST;
            r_cfg.long_min  <= LONG_MIN_RST;
            r_cfg.long_max  <= LONG_MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hw/rtl/bipir_decode.sv
module bipir_decode
    import bipir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [WIDTH_W-1:0] i_width,
    input  t_cfg               i_cfg,
    output logic               o_res_valid,
    output t_result            o_res
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [SHIFT_W-1:0] r_shift;
    logic [SHIFT_W-1:0] n_shift;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_pulse_cls         cls;
    logic               err;
    logic               push;
    logic               push_bit;
    logic               done;

    // Short window wins where the two overlap
    always_comb begin
        if ((i_width >= i_cfg.short_min) && (i_width <= i_cfg.short_max)) begin
            cls = CLS_SHORT;
        end else if ((i_width >= i_cfg.long_min) && (i_width <= i_cfg.long_max)) begin
            cls = CLS_LONG;
        end else begin
            cls = CLS_NONE;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        err      = 1'b0;
        push     = 1'b0;
        push_bit = 1'b0;
        case (r_phase)
            PH_MID1: begin
                if (cls == CLS_SHORT) begin
                    n_phase = PH_START1;
                end else if (cls == CLS_LONG) begin
                    push    = 1'b1;
                    n_phase = PH_MID0;
                end else begin
                    err = 1'b1;
                end
            end
            PH_START1: begin
                if (cls == CLS_SHORT) begin
                    push     = 1'b1;
                    push_bit = 1'b1;
                    n_phase  = PH_MID1;
                end else begin
                    err = 1'b1;
                end
            end
            PH_MID0: begin
                if (cls == CLS_SHORT) begin
                    n_phase = PH_START0;
                end else if (cls == CLS_LONG) begin
                    push     = 1'b1;
                    push_bit = 1'b1;
                    n_phase  = PH_MID1;
                end else begin
                    err = 1'b1;
                end
            end
            PH_START0: begin
                if (cls == CLS_SHORT) begin
                    push    = 1'b1;
                    n_phase = PH_MID0;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
                n_phase = PH_MID1;
            end
        endcase

        // Start phase: first pulse is the leading 1 bit, whatever its width
        if (r_phase == PH_MID1 || r_phase == PH_START1 || r_phase == PH_MID0 ||
            r_phase == PH_START0) begin
            n_shift = push ? {r_shift[SHIFT_W-2:0], push_bit} : r_shift;
            n_count = push ? r_count + COUNT_W'(1) : r_count;
        end else begin
            n_shift = SHIFT_W'(1);
            n_count = COUNT_W'(1);
        end

        done = err || (n_count == FRAME_COUNT);

        o_res_valid         = i_fire && done;
        o_res.command       = n_shift;
        o_res.frame_error   = err;
        o_res.bits_received = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_shift <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            if (done) begin
                r_phase <= PH_START;
                r_shift <= '0;
                r_count <= '0;
            end else begin
                r_phase <= n_phase;
                r_shift <= n_shift;
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: hw/rtl/bipir_out_buf.sv
module bipir_out_buf
    import bipir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load_valid,
    input  t_result i_load,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_full
);

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    take;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

    always_comb begin
        take         = !r_out_valid || !i_stall;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_load_valid;
                n_out       = i_load;
            end
        end else if (i_load_valid) begin
            // head stalled: park the new result
            n_skid_valid = 1'b1;
            n_skid       = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule
